/* rtl/core/reciprocal_freq_to_morse_digits_core_macros.svh */
// Assertion macros for the checker file of the frequency readout core.
// No dependencies; include by bare file name.
`ifndef RECIPROCAL_FREQ_TO_MORSE_DIGITS_CORE_MACROS_SVH
`define RECIPROCAL_FREQ_TO_MORSE_DIGITS_CORE_MACROS_SVH

// Concurrent implication check, held off while reset is asserted.
`define RFMD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check, also evaluated during reset.
`define RFMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rfmd_pkg.sv */
// Package of the reciprocal frequency counter Morse readout: beat types,
// constants and the Morse symbol function. No dependencies.
package rfmd_pkg;

  localparam int unsigned NUM_DIGITS     = 5;
  localparam int unsigned SYMS_PER_DIGIT = 5;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Divider: dividend is a constant, divisor is always at least 2^15 - 1,
  // so the quotient fits in 17 bits and the top 15 dividend bits seed it.
  localparam int unsigned QUOT_BITS      = 17;
  localparam logic [31:0] FREQ_NUMERATOR = 32'd2592000000;
  localparam logic [15:0] FREQ_OFFSET    = 16'd10000;
  localparam logic [15:0] CW_SHIFT       = 16'd7;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam logic [7:0] MORSE_BIAS  = 8'd6;
  localparam logic [7:0] MORSE_LIMIT = 8'd250;

  localparam logic [2:0] GAP_SYMBOL = 3'd1;
  localparam logic [2:0] GAP_DIGIT  = 3'd3;
  localparam logic [2:0] GAP_WORD   = 3'd7;

  localparam logic [2:0] LAST_POS = 3'(NUM_DIGITS - 1);
  localparam logic [2:0] LAST_SYM = 3'(SYMS_PER_DIGIT - 1);

  typedef struct packed {
    logic [7:0] start_count;
    logic [7:0] coarse_count;
    logic [7:0] end_count;
  } rfmd_in_t;

  typedef struct packed {
    logic [15:0] frequency_code;
    logic [2:0]  digit_position;
    logic [3:0]  digit_value;
    logic        is_dah;
    logic [2:0]  gap_units;
    logic        last_symbol;
  } rfmd_out_t;

  // Classified measurement: period word and the bit kept aside
  typedef struct packed {
    logic [15:0] word;
    logic        kept;
  } rfmd_work_t;

  // Converted measurement: code and its decimal digits, index 0 most significant
  typedef struct packed {
    logic [15:0]                  code;
    logic [NUM_DIGITS-1:0][3:0]   digit;
  } rfmd_digits_t;

  // Symbol i of digit d is a dit when (d - 6 - i) mod 256 exceeds 250
  function automatic logic morse_is_dah(input logic [3:0] d, input logic [2:0] i);
    logic [7:0] biased;
    biased = {4'b0, d} - MORSE_BIAS - {5'b0, i};
    return !(biased > MORSE_LIMIT);
  endfunction

endpackage

/* rtl/core/rfmd_front.sv */
// Front stage: forms the period word from the three counter samples and
// pushes it into the work queue. Depends on rfmd_pkg.
module rfmd_front (
  input  logic                 push,
  output logic                 full,
  input  rfmd_pkg::rfmd_in_t   meas_i,
  output logic                 wr_valid_o,
  output rfmd_pkg::rfmd_work_t wr_data_o,
  input  logic                 q_full_i
);
  import rfmd_pkg::*;

  logic [7:0] fine;
  logic [7:0] crs;
  logic [7:0] crs_adj;
  logic [5:0] crs_sh;

  // Sample differences, borrow correction and coarse scaling
  always_comb begin
    fine    = meas_i.end_count - meas_i.start_count;
    crs     = meas_i.coarse_count - meas_i.start_count;
    crs_adj = fine[7] ? crs - 8'd1 : crs;
    crs_sh  = crs_adj[7:2];
  end

  // Halve, set bit 15, subtract one
  assign wr_data_o.word = {1'b1, 2'b00, crs_sh, fine[7:1]} - 16'd1;
  assign wr_data_o.kept = fine[0];

  assign full       = q_full_i;
  assign wr_valid_o = push && !q_full_i;

endmodule

/* rtl/core/rfmd_queue.sv */
// Small work queue between front and back stages.
// Depends on rfmd_pkg.
module rfmd_queue #(
  parameter int unsigned Depth = rfmd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  input  rfmd_pkg::rfmd_work_t wr_data_i,
  output logic                 full_o,
  output logic                 rd_valid_o,
  input  logic                 rd_ready_i,
  output rfmd_pkg::rfmd_work_t rd_data_o
);
  import rfmd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  rfmd_work_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_wr, do_rd;

  assign full_o     = (count_q == DepthCnt);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/core/rfmd_div.sv */
// Back stage, part one: restoring divider for the frequency code and a
// digit splitter using a reciprocal multiply. Depends on rfmd_pkg.
module rfmd_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cw_shift_i,
  input  logic                   work_valid_i,
  input  rfmd_pkg::rfmd_work_t   work_i,
  output logic                   work_ready_o,
  output logic                   res_valid_o,
  output rfmd_pkg::rfmd_digits_t res_o,
  input  logic                   res_take_i
);
  import rfmd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CODE  = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int unsigned StepW = $clog2(QUOT_BITS);
  localparam logic [StepW-1:0] LastStep = StepW'(QUOT_BITS - 1);

  logic [2:0]               state_q, state_d;
  logic [15:0]              divisor_q;
  logic                     kept_q;
  logic [15:0]              rem_q;
  logic [QUOT_BITS-1:0]     quot_q;
  logic [QUOT_BITS-1:0]     num_q;
  logic [StepW-1:0]         step_q;
  logic [15:0]              val_q;
  logic [15:0]              code_q;
  logic [2:0]               dpos_q;
  logic [NUM_DIGITS-1:0][3:0] digit_q;

  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [16:0] rem_sub;
  logic [31:0] prod;
  logic [15:0] quo10;
  logic [15:0] rem10;
  logic [15:0] shift_amt;

  // One quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, num_q[QUOT_BITS-1]};
    rem_ge  = (rem_sh >= {1'b0, divisor_q});
    rem_sub = rem_sh - {1'b0, divisor_q};
  end

  // One decimal digit per cycle
  always_comb begin
    prod      = val_q * DIV10_MUL;
    quo10     = 16'(prod >> DIV10_SHIFT);
    rem10     = val_q - ({quo10[12:0], 3'b000} + {quo10[14:0], 1'b0});
    shift_amt = cw_shift_i ? CW_SHIFT : 16'd0;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (work_valid_i) state_d = ST_DIV;
      ST_DIV:   if (step_q == LastStep) state_d = ST_CODE;
      ST_CODE:  state_d = ST_DIGIT;
      ST_DIGIT: if (dpos_q == '0) state_d = ST_DONE;
      ST_DONE:  if (res_take_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        divisor_q <= work_i.word;
        kept_q    <= work_i.kept;
        rem_q     <= {1'b0, FREQ_NUMERATOR[31:QUOT_BITS]};
        num_q     <= FREQ_NUMERATOR[QUOT_BITS-1:0];
        quot_q    <= '0;
        step_q    <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
        quot_q <= {quot_q[QUOT_BITS-2:0], rem_ge};
        num_q  <= {num_q[QUOT_BITS-2:0], 1'b0};
        step_q <= step_q + StepW'(1);
      end
      ST_CODE: begin
        code_q <= quot_q[15:0] - FREQ_OFFSET - {15'b0, kept_q} - shift_amt;
        val_q  <= quot_q[15:0] - FREQ_OFFSET - {15'b0, kept_q} - shift_amt;
        dpos_q <= LAST_POS;
      end
      ST_DIGIT: begin
        digit_q[dpos_q] <= rem10[3:0];
        val_q           <= quo10;
        dpos_q          <= dpos_q - 3'd1;
      end
      default: begin
      end
    endcase
  end

  assign work_ready_o = (state_q == ST_IDLE);
  assign res_valid_o  = (state_q == ST_DONE);
  assign res_o.code   = code_q;
  assign res_o.digit  = digit_q;

endmodule

/* rtl/core/rfmd_morse.sv */
// Back stage, part two: steps through the 25 Morse symbols of a measurement
// and presents each on the result port. Depends on rfmd_pkg.
module rfmd_morse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  input  rfmd_pkg::rfmd_digits_t res_i,
  output logic                   res_take_o,
  output logic                   empty,
  input  logic                   pop,
  output rfmd_pkg::rfmd_out_t    sym_o
);
  import rfmd_pkg::*;

  logic                       busy_q;
  logic [2:0]                 pos_q;
  logic [2:0]                 sym_q;
  logic [15:0]                code_q;
  logic [NUM_DIGITS-1:0][3:0] digit_q;
  logic                       last;
  logic                       advance;
  logic [3:0]                 cur_digit;

  assign last       = (pos_q == LAST_POS) && (sym_q == LAST_SYM);
  assign advance    = busy_q && pop;
  assign res_take_o = res_valid_i && (!busy_q || (advance && last));
  assign empty      = !busy_q;

  // Symbol sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      sym_q  <= '0;
    end else if (res_take_o) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
      sym_q  <= '0;
    end else if (advance) begin
      if (last) begin
        busy_q <= 1'b0;
      end else if (sym_q == LAST_SYM) begin
        sym_q <= '0;
        pos_q <= pos_q + 3'd1;
      end else begin
        sym_q <= sym_q + 3'd1;
      end
    end
  end

  // Measurement payload; leading digit carries its +1
  always_ff @(posedge clk_i) begin
    if (res_take_o) begin
      code_q  <= res_i.code;
      digit_q <= {res_i.digit[NUM_DIGITS-1:1], res_i.digit[0] + 4'd1};
    end
  end

  // Symbol decode
  always_comb begin
    cur_digit            = digit_q[pos_q];
    sym_o.frequency_code = code_q;
    sym_o.digit_position = pos_q;
    sym_o.digit_value    = cur_digit;
    sym_o.is_dah         = morse_is_dah(cur_digit, sym_q);
    sym_o.last_symbol    = last;
    if (sym_q != LAST_SYM) begin
      sym_o.gap_units = GAP_SYMBOL;
    end else if (pos_q == 3'd0 || pos_q == 3'd3) begin
      sym_o.gap_units = GAP_WORD;
    end else begin
      sym_o.gap_units = GAP_DIGIT;
    end
  end

endmodule

/* rtl/core/reciprocal_freq_to_morse_digits_core.sv */
// Reciprocal frequency counter readout: one measurement in, 25 Morse
// symbols of its five-digit frequency code out.
// Depends on rfmd_pkg, rfmd_front, rfmd_queue, rfmd_div, rfmd_morse.
//
// Input side is a queue: a measurement (three counter samples) is taken
// when push is high and full is low. It is classified at once and parked
// in a work queue of QueueDepth entries; full rises only when that queue
// is full. The result side is a queue too: while empty is low the oldest
// symbol is on sym_o and pop takes it. The configuration channel
// (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the CW shift enable bit;
// it is always ready.
// Path: the divider loads the word and forms the 17 quotient bits, the
// code is formed, the five digits are split and the result is handed
// to the symbol sequencer, which then shows the first symbol.
// Throughput: one symbol per cycle while pop is held; the divider of
// the next measurement runs while the current one is sent, and the
// symbol sequencer sets the pace.
// A stalled receiver holds the current symbol; the divider then waits
// with its finished result, and the work queue fills behind it.
// Reset clears all queues and the shift enable bit.
module reciprocal_freq_to_morse_digits_core #(
  parameter int unsigned QueueDepth = rfmd_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  rfmd_pkg::rfmd_in_t  meas_i,
  output logic                empty,
  input  logic                pop,
  output rfmd_pkg::rfmd_out_t sym_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import rfmd_pkg::*;

  logic         cw_shift_q;
  logic         q_wr_valid;
  rfmd_work_t   q_wr_data;
  logic         q_full;
  logic         q_rd_valid;
  logic         q_rd_ready;
  rfmd_work_t   q_rd_data;
  logic         res_valid;
  logic         res_take;
  rfmd_digits_t res_data;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_shift_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cw_shift_q <= cfg_data_i;
    end
  end

  rfmd_front u_front (
    .push       (push),
    .full       (full),
    .meas_i     (meas_i),
    .wr_valid_o (q_wr_valid),
    .wr_data_o  (q_wr_data),
    .q_full_i   (q_full)
  );

  rfmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (q_wr_valid),
    .wr_data_i  (q_wr_data),
    .full_o     (q_full),
    .rd_valid_o (q_rd_valid),
    .rd_ready_i (q_rd_ready),
    .rd_data_o  (q_rd_data)
  );

  rfmd_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cw_shift_i   (cw_shift_q),
    .work_valid_i (q_rd_valid),
    .work_i       (q_rd_data),
    .work_ready_o (q_rd_ready),
    .res_valid_o  (res_valid),
    .res_o        (res_data),
    .res_take_i   (res_take)
  );

  rfmd_morse u_morse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_data),
    .res_take_o  (res_take),
    .empty       (empty),
    .pop         (pop),
    .sym_o       (sym_o)
  );

endmodule

/* rtl/core/rfmd_checker.sv */
// Port-level checker for the frequency readout core, bound to the top level.
// Depends on rfmd_pkg and the core assertion macros header.
`include "reciprocal_freq_to_morse_digits_core_macros.svh"

module rfmd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input rfmd_pkg::rfmd_out_t sym_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o
);
  import rfmd_pkg::*;

  logic in_beat;
  logic cfg_beat;
  assign in_beat  = push && !full;
  assign cfg_beat = cfg_valid_i && cfg_ready_o;

  // A waiting symbol that is not popped stays put
  `RFMD_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(sym_o)), "symbol changed while stalled")

  // The final symbol closes the last digit
  `RFMD_ASSERT(a_last, clk_i, rst_ni, (!empty && sym_o.last_symbol) |-> ((sym_o.digit_position == LAST_POS) && (sym_o.gap_units == GAP_DIGIT)), "last symbol misplaced")

  // Within a measurement the code does not change from one symbol to the next
  `RFMD_ASSERT(a_code, clk_i, rst_ni, (!empty && pop && !sym_o.last_symbol) |=> (!empty && $stable(sym_o.frequency_code)), "code changed inside a measurement")

  // Configuration beats only land while the block is drained and idle
  `RFMD_ASSERT(a_cfg_idle, clk_i, rst_ni, cfg_beat |-> (empty && !in_beat), "configuration written with work in flight")

  // After reset nothing is waiting and the input side is open
  `RFMD_ASSERT_ALWAYS(a_reset, clk_i, !rst_ni |=> (!rst_ni || (empty && !full)), "output not empty after reset")

endmodule

bind reciprocal_freq_to_morse_digits_core rfmd_checker u_rfmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .sym_o       (sym_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

/* bench/tb_top.sv */
// Testbench of the reciprocal frequency counter Morse readout core.
// Predicts the 25 symbols of every measurement and checks them in order.
// Depends on rfmd_pkg and reciprocal_freq_to_morse_digits_core.
module tb_top;
  import rfmd_pkg::*;

  localparam int unsigned SYMS_PER_MEAS = NUM_DIGITS * SYMS_PER_DIGIT;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned TAIL_CYCLES   = 60;
  localparam int unsigned RAND_PHASES   = 4;
  localparam int unsigned RAND_ITEMS    = 90;

  // Symbol predictor and queue of symbols still to arrive
  class morse_scoreboard;
    rfmd_out_t want_q[$];
    bit        cw_shift;
    int        errors;

    function new();
      cw_shift = 1'b0;
      errors   = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // Derive the frequency code and queue its 25 Morse symbols
    function void note_measurement(rfmd_in_t m);
      logic [7:0]  fine;
      logic [7:0]  crs;
      logic        kept;
      logic [15:0] word;
      logic [31:0] quot;
      logic [31:0] code32;
      logic [15:0] code;
      int unsigned rest;
      logic [3:0]  dig [NUM_DIGITS];
      logic [7:0]  biased;
      rfmd_out_t   sym;
      int          n;
      fine = m.end_count - m.start_count;
      crs  = m.coarse_count - m.start_count;
      if (fine[7]) begin
        crs = crs - 8'd1;
      end
      crs  = crs >> 2;
      kept = fine[0];
      word = {crs, fine} >> 1;
      word = (word | 16'h8000) - 16'd1;
      quot = FREQ_NUMERATOR / {16'd0, word};
      code32 = quot - {16'd0, FREQ_OFFSET} - {31'd0, kept};
      if (cw_shift) begin
        code32 = code32 - {16'd0, CW_SHIFT};
      end
      code = code32[15:0];
      // decimal split, least significant digit first, into the last index
      rest = code;
      for (int pos = NUM_DIGITS - 1; pos >= 0; pos--) begin
        dig[pos] = 4'(rest % 10);
        rest     = rest / 10;
      end
      dig[0] = dig[0] + 4'd1;
      n = 0;
      for (int pos = 0; pos < NUM_DIGITS; pos++) begin
        for (int i = 0; i < SYMS_PER_DIGIT; i++) begin
          biased             = {4'd0, dig[pos]} - MORSE_BIAS - 8'(i);
          sym.frequency_code = code;
          sym.digit_position = 3'(pos);
          sym.digit_value    = dig[pos];
          sym.is_dah         = !(biased > MORSE_LIMIT);
          if (i == SYMS_PER_DIGIT - 1) begin
            sym.gap_units = (pos == 0 || pos == 3) ? GAP_WORD : GAP_DIGIT;
          end else begin
            sym.gap_units = GAP_SYMBOL;
          end
          sym.last_symbol = (n == SYMS_PER_MEAS - 1);
          want_q.push_back(sym);
          n++;
        end
      end
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t mismatch %s: expected %0d actual %0d", $time, field, want, got);
      errors++;
    endfunction

    // Compare one accepted symbol with the oldest one predicted
    function void check_symbol(rfmd_out_t got);
      rfmd_out_t want;
      if (want_q.size() == 0) begin
        $display("%0t unexpected symbol: actual code %0d pos %0d", $time,
                 got.frequency_code, got.digit_position);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.frequency_code !== want.frequency_code)
        report("frequency_code", want.frequency_code, got.frequency_code);
      if (got.digit_position !== want.digit_position)
        report("digit_position", want.digit_position, got.digit_position);
      if (got.digit_value !== want.digit_value)
        report("digit_value", want.digit_value, got.digit_value);
      if (got.is_dah !== want.is_dah)
        report("is_dah", want.is_dah, got.is_dah);
      if (got.gap_units !== want.gap_units)
        report("gap_units", want.gap_units, got.gap_units);
      if (got.last_symbol !== want.last_symbol)
        report("last_symbol", want.last_symbol, got.last_symbol);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  rfmd_in_t  meas;
  logic      empty;
  logic      pop;
  rfmd_out_t sym;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  logic [15:0] stall_mask = 16'd0;
  logic [3:0]  stall_ph   = 4'd0;
  int unsigned idle_cycles = 0;

  morse_scoreboard sb;

  reciprocal_freq_to_morse_digits_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .meas_i      (meas),
    .empty       (empty),
    .pop         (pop),
    .sym_o       (sym),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: pop follows a rotating stall pattern
  always @(negedge clk_i) begin
    pop      <= !stall_mask[stall_ph];
    stall_ph <= stall_ph + 4'd1;
  end

  // Monitor: note accepted measurements, check accepted symbols
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_measurement(meas);
      end
      if (pop && !empty) begin
        sb.check_symbol(sym);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Drive one measurement and hold it until accepted
  task automatic send_counts(input logic [7:0] s, input logic [7:0] c, input logic [7:0] e);
    @(negedge clk_i);
    push <= 1'b1;
    meas <= rfmd_in_t'({s, c, e});
    do @(posedge clk_i); while (full);
  endtask

  task automatic idle_inputs(input int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Let every predicted symbol arrive
  task automatic wait_drained();
    idle_inputs(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_shift(input logic v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    sb.cw_shift = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Edge cases: zero and full-scale samples, fine bit 7 borrow, kept bit,
  // wrapped codes, modular sample differences
  task automatic send_edges(input logic [7:0] ofs);
    send_counts(ofs, ofs, ofs);
    send_counts(8'd255 + ofs, 8'd255 + ofs, 8'd255 + ofs);
    send_counts(ofs, 8'd255 + ofs, 8'd255 + ofs);
    send_counts(ofs, ofs, 8'd128 + ofs);
    idle_inputs(3);
    send_counts(ofs, ofs, 8'd127 + ofs);
    send_counts(ofs, ofs, 8'd1 + ofs);
    send_counts(ofs, 8'd252 + ofs, 8'd128 + ofs);
    send_counts(ofs, 8'd253 + ofs, 8'd127 + ofs);
    idle_inputs(7);
    send_counts(8'd200, 8'd100, 8'd50);
    send_counts(8'h55, 8'hAA, 8'h55);
    send_counts(8'hAA, 8'h55, 8'hAA);
    send_counts(8'd17 + ofs, 8'd25 + ofs, 8'd217 + ofs);
  endtask

  // Random measurements sent in bursts with random gaps
  task automatic send_random(input int unsigned count, input int unsigned gap_max);
    int unsigned sent;
    int unsigned burst;
    logic [7:0]  s;
    logic [7:0]  c;
    logic [7:0]  e;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < count) begin
        s = $urandom;
        c = $urandom;
        e = $urandom;
        // some near the fine bit 7 boundary and near a zero coarse count
        if ($urandom_range(0, 5) == 0) begin
          c = s + 8'($urandom_range(0, 4));
          e = s + 8'($urandom_range(124, 132));
        end
        send_counts(s, c, e);
        burst--;
        sent++;
      end
      if (gap_max > 0) begin
        idle_inputs($urandom_range(0, gap_max));
      end
    end
  endtask

  initial begin
    sb        = new();
    rst_ni    = 1'b0;
    push      = 1'b0;
    meas      = '0;
    pop       = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, shift off then on
    write_shift(1'b0);
    send_edges(8'd0);
    wait_drained();
    stall_mask = 16'($urandom) & 16'hFFFE;
    write_shift(1'b1);
    send_edges(8'd93);
    wait_drained();

    // Random phases with alternating shift and varied pressure
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          stall_mask = 16'($urandom) & 16'hFFFE;
        end
        1: begin
          stall_mask = (16'($urandom) | 16'hFFF0) & 16'hFFFE;
        end
        2: begin
          stall_mask = 16'd0;
        end
        default: begin
          stall_mask = 16'($urandom) & 16'h7FFE;
        end
      endcase
      write_shift(ph[0]);
      send_random(RAND_ITEMS, (ph == 2) ? 0 : 40);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
